@@ rtl/core/alpha_blend_clipped_blit_assert.svh @@
// Assertion macros used by the blitter RTL.
`ifndef ALPHA_BLEND_CLIPPED_BLIT_ASSERT_SVH
`define ALPHA_BLEND_CLIPPED_BLIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ABCB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("blitter check failed");

// The consequent must hold in the cycle after the antecedent.
`define ABCB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("blitter check failed");

`endif

@@ rtl/core/abcb_pkg.sv @@
package abcb_pkg;

  // Largest bitmap side that the counters cover.
  localparam int unsigned MaxSide = 1024;

  localparam int unsigned CountW  = 10;
  localparam int unsigned SideW   = 11;
  localparam int unsigned OriginW = 12;
  localparam int unsigned CfgW    = 12;
  localparam int unsigned IndexW  = 20;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    RegOriginX      = 3'd0,
    RegOriginY      = 3'd1,
    RegBitmapWidth  = 3'd2,
    RegBitmapHeight = 3'd3,
    RegScreenWidth  = 3'd4,
    RegScreenHeight = 3'd5
  } cfg_reg_e;

  // What the first stage hands to the blend and address stage.
  typedef struct packed {
    logic [31:0]      src;
    logic [31:0]      dst;
    logic [SideW-1:0] col;
    logic [SideW-1:0] row;
    logic             on;
    logic             last;
  } stage_t;

  // A bitmap side of zero counts as one, anything above MaxSide as MaxSide.
  function automatic logic [SideW-1:0] eff_side(input logic [SideW-1:0] v);
    logic [SideW-1:0] r;
    if (v == '0) begin
      r = SideW'(1);
    end else if (v > SideW'(MaxSide)) begin
      r = SideW'(MaxSide);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // round((d*(255-a) + s*a) / 255) with halves rounded up.
  // Adding 127 turns the rounding into a floor; the floor division by 255
  // is the usual add-and-shift form, exact for every sum that can occur here (at most 65152).
  function automatic logic [7:0] blend_chan(input logic [7:0] d, input logic [7:0] s,
                                            input logic [7:0] a);
    logic [15:0] n;
    logic [15:0] x;
    logic [15:0] q;
    n = 16'(16'(d) * 16'(8'hFF - a)) + 16'(16'(s) * 16'(a));
    x = n + 16'd127;
    q = x + 16'(x[15:8]) + 16'd1;
    return q[15:8];
  endfunction

endpackage

@@ rtl/core/alpha_blend_clipped_blit.sv @@
// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+------------------------------------------
// input     | in        | in_valid/in_stall  | src_pixel, dest_pixel
// result    | out       | out_valid/out_stall| write_enable, pixel_index, blended_pixel, last
// config    | in        | cfg_we             | cfg_index, cfg_wdata
//
// One pixel is accepted per cycle while in_stall is low; results are registered.
// The first stage forms the screen position and clip test, the second the blend
// (two 8x8 products per channel) and the row times stride product of the index.
// Reset clears the valid bits and both counters and loads the register reset values.
// A stalled result holds; the input stage keeps accepting until both stages are full.
`include "alpha_blend_clipped_blit_assert.svh"

module alpha_blend_clipped_blit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] src_pixel_i,
  input  logic [31:0] dest_pixel_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        write_enable_o,
  output logic [19:0] pixel_index_o,
  output logic [23:0] blended_pixel_o,
  output logic        last_o
);

  // Configuration registers.
  logic [abcb_pkg::OriginW-1:0] origin_x_q, origin_y_q;
  logic [abcb_pkg::SideW-1:0]   bitmap_width_q, bitmap_height_q;
  logic [abcb_pkg::SideW-1:0]   screen_width_q, screen_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q      <= '0;
      origin_y_q      <= '0;
      bitmap_width_q  <= abcb_pkg::SideW'(1);
      bitmap_height_q <= abcb_pkg::SideW'(1);
      screen_width_q  <= abcb_pkg::SideW'(abcb_pkg::MaxSide);
      screen_height_q <= abcb_pkg::SideW'(abcb_pkg::MaxSide);
    end else if (cfg_we_i) begin
      unique case (abcb_pkg::cfg_reg_e'(cfg_index_i))
        abcb_pkg::RegOriginX:      origin_x_q      <= cfg_wdata_i;
        abcb_pkg::RegOriginY:      origin_y_q      <= cfg_wdata_i;
        abcb_pkg::RegBitmapWidth:  bitmap_width_q  <= cfg_wdata_i[abcb_pkg::SideW-1:0];
        abcb_pkg::RegBitmapHeight: bitmap_height_q <= cfg_wdata_i[abcb_pkg::SideW-1:0];
        abcb_pkg::RegScreenWidth:  screen_width_q  <= cfg_wdata_i[abcb_pkg::SideW-1:0];
        abcb_pkg::RegScreenHeight: screen_height_q <= cfg_wdata_i[abcb_pkg::SideW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control: a stage moves when the result register is free or drained.
  logic stage_valid_q, out_valid_q;
  logic advance, in_xfer;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = stage_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Position within the bitmap and the clip test.
  logic [abcb_pkg::CountW-1:0] col_count_q, row_count_q;
  logic [abcb_pkg::SideW-1:0]  bw_eff, bh_eff;
  logic                        end_col, end_row, last_now, on_now;
  logic signed [12:0]          pos_x, pos_y;

  always_comb begin
    bw_eff   = abcb_pkg::eff_side(bitmap_width_q);
    bh_eff   = abcb_pkg::eff_side(bitmap_height_q);
    end_col  = {1'b0, col_count_q} >= (bw_eff - abcb_pkg::SideW'(1));
    end_row  = {1'b0, row_count_q} >= (bh_eff - abcb_pkg::SideW'(1));
    last_now = end_col && end_row;
    pos_x    = $signed({origin_x_q[11], origin_x_q}) + $signed({3'b000, col_count_q});
    pos_y    = $signed({origin_y_q[11], origin_y_q}) + $signed({3'b000, row_count_q});
    on_now   = !pos_x[12] && !pos_y[12] &&
               (pos_x[11:0] < {1'b0, screen_width_q}) &&
               (pos_y[11:0] < {1'b0, screen_height_q});
  end

  // Counters step on every input transfer and wrap at the bitmap's edges.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_count_q <= '0;
      row_count_q <= '0;
    end else if (in_xfer) begin
      if (end_col) begin
        col_count_q <= '0;
        row_count_q <= end_row ? '0 : row_count_q + abcb_pkg::CountW'(1);
      end else begin
        col_count_q <= col_count_q + abcb_pkg::CountW'(1);
      end
    end
  end

  // Input stage register.
  abcb_pkg::stage_t stage_d, stage_q;

  always_comb begin
    stage_d.src  = src_pixel_i;
    stage_d.dst  = dest_pixel_i;
    stage_d.col  = pos_x[abcb_pkg::SideW-1:0];
    stage_d.row  = pos_y[abcb_pkg::SideW-1:0];
    stage_d.on   = on_now;
    stage_d.last = last_now;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (advance || in_xfer) begin
      stage_valid_q <= in_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      stage_q <= stage_d;
    end
  end

  // Blend and address: two products per channel and one for row times stride.
  logic [21:0] row_base;
  logic [19:0] index_d;
  logic [23:0] pixel_d;
  logic [7:0]  alpha;

  always_comb begin
    alpha    = stage_q.src[31:24];
    row_base = 22'(stage_q.row) * 22'(screen_width_q);
    index_d  = 20'(row_base + 22'(stage_q.col));
    pixel_d  = {abcb_pkg::blend_chan(stage_q.dst[23:16], stage_q.src[23:16], alpha),
                abcb_pkg::blend_chan(stage_q.dst[15:8],  stage_q.src[15:8],  alpha),
                abcb_pkg::blend_chan(stage_q.dst[7:0],   stage_q.src[7:0],   alpha)};
    if (!stage_q.on) begin
      index_d = '0;
      pixel_d = '0;
    end
  end

  // Result register.
  logic        we_q, last_q;
  logic [19:0] index_q;
  logic [23:0] pixel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= stage_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && stage_valid_q) begin
      we_q    <= stage_q.on;
      last_q  <= stage_q.last;
      index_q <= index_d;
      pixel_q <= pixel_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign write_enable_o  = we_q;
  assign pixel_index_o   = index_q;
  assign blended_pixel_o = pixel_q;
  assign last_o          = last_q;

  // An off-screen result carries neither an index nor a color.
  `ABCB_ASSERT_NOW(a_offscreen_zero, out_valid_o && !write_enable_o,
                   pixel_index_o == '0 && blended_pixel_o == '0)
  // After the final pixel of a bitmap both counters start over.
  `ABCB_ASSERT_NEXT(a_counters_wrap, in_xfer && last_now,
                    col_count_q == '0 && row_count_q == '0)
  // A held item in the first stage reaches the result register once it can move.
  `ABCB_ASSERT_NEXT(a_stage_moves, stage_valid_q && advance, out_valid_q)

endmodule
